// ===== rtl/stt_pkg.sv =====
package stt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int VALUE_BITS_DEFAULT  = 4;
   localparam int SUIT_BITS           = 8;
   localparam int IN_VALUE_BITS       = 4;
   localparam int OUT_COUNT_BITS      = 5;
   localparam int OUT_TOTAL_BITS      = 8;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_DONE = 2'd0;
   localparam status_type STATUS_FULL = 2'd1;
   localparam status_type STATUS_MISS = 2'd2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic [IN_VALUE_BITS-1:0] card_value;
      logic [SUIT_BITS-1:0]     card_suit;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [OUT_COUNT_BITS-1:0] entry_count;
      logic [OUT_TOTAL_BITS-1:0] value_total;
      logic                      head_valid;
      logic [IN_VALUE_BITS-1:0]  head_value;
      logic [SUIT_BITS-1:0]      head_suit;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic apply;
   } cmd_type;

endpackage

// ===== rtl/sorted_two_key_table.sv =====
// Sorted table of up to TABLE_DEPTH (value, suit) entries kept in ascending order, by value
// then suit. Each request transaction inserts (mode 0) or deletes (mode 1) one entry and
// yields exactly one response transaction with status, count, value sum and head entry.
// Every entry sits in its own cell; all cells compare against the new key in parallel, and
// the cells shift together once the compare results are registered, so a transaction passes
// the accept, compare and shift steps on its way to a registered response, independent of
// table depth. A new request is taken while the previous response waits in its output
// register; the shift step holds only if that response has still not been taken.
module sorted_two_key_table #(
   parameter int TABLE_DEPTH = stt_pkg::TABLE_DEPTH_DEFAULT,
   parameter int VALUE_BITS  = stt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stt_pkg::rsp_type rsp_data
);
   import stt_pkg::*;

   localparam logic [OUT_COUNT_BITS-1:0] FULL_COUNT =
      (TABLE_DEPTH > 31) ? OUT_COUNT_BITS'(31) : OUT_COUNT_BITS'(TABLE_DEPTH);

   cmd_type cmd;

   stt_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   stt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous transaction in flight");

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.head_valid == (rsp_data.entry_count != '0)))
      else $error("head_valid disagrees with entry_count");

   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.entry_count == '0)) |-> (rsp_data.value_total == '0))
      else $error("non-zero total on empty table");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_FULL)) |-> (rsp_data.entry_count == FULL_COUNT))
      else $error("full status with table not full");

endmodule

// ===== rtl/stt_control.sv =====
module stt_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stt_pkg::cmd_type cmd
);
   import stt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_APPLY
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      apply_go;

   assign apply_go = (state_ff == ST_APPLY) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.load    = (state_ff == ST_IDLE) && req_valid;
   assign cmd.compare = (state_ff == ST_COMPARE);
   assign cmd.apply   = apply_go;

endmodule

// ===== rtl/stt_datapath.sv =====
module stt_datapath #(
   parameter int TABLE_DEPTH = stt_pkg::TABLE_DEPTH_DEFAULT,
   parameter int VALUE_BITS  = stt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  stt_pkg::cmd_type cmd,
   input  stt_pkg::req_type req_data,
   output stt_pkg::rsp_type rsp_data
);
   import stt_pkg::*;

   localparam int KEY_BITS = VALUE_BITS + SUIT_BITS;
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int TOT_BITS = $clog2(TABLE_DEPTH * ((1 << VALUE_BITS) - 1) + 1);

   logic [KEY_BITS-1:0]   slot_ff [TABLE_DEPTH];
   logic [KEY_BITS-1:0]   slot_in [TABLE_DEPTH];
   logic [KEY_BITS-1:0]   prev_key [TABLE_DEPTH];
   logic [KEY_BITS-1:0]   next_key [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] prev_ins;

   logic                  mode_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;

   logic [TABLE_DEPTH-1:0] ge_ff, ge_in;
   logic [TABLE_DEPTH-1:0] eq_ff, eq_in;
   logic [TABLE_DEPTH-1:0] ins_ff, ins_in;
   logic                   full_ff, full_in;

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [TOT_BITS-1:0] total_ff, total_in;
   status_type          status_in;
   rsp_type             rsp_ff, rsp_in;
   logic                found;

   always_comb begin
      logic cell_valid;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         cell_valid = (CNT_BITS'(i) < count_ff);
         ge_in[i]   = cell_valid && (slot_ff[i] >= key_ff);
         eq_in[i]   = cell_valid && (slot_ff[i] == key_ff);
         ins_in[i]  = ge_in[i] || (CNT_BITS'(i) == count_ff);
      end
      full_in = (count_ff == CNT_BITS'(TABLE_DEPTH));
   end

   // neighbour taps of the cell row
   always_comb begin
      prev_key[0] = key_ff;
      prev_ins[0] = 1'b0;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         prev_key[i] = slot_ff[i-1];
         prev_ins[i] = ins_ff[i-1];
      end
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
         next_key[i] = slot_ff[i+1];
      end
      next_key[TABLE_DEPTH-1] = slot_ff[TABLE_DEPTH-1];
   end

   assign found = |eq_ff;

   always_comb begin
      slot_in   = slot_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      status_in = STATUS_DONE;
      if (mode_ff == MODE_INSERT) begin
         if (full_ff) begin
            status_in = STATUS_FULL;
         end else begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (ins_ff[i]) begin
                  slot_in[i] = prev_ins[i] ? prev_key[i] : key_ff;
               end
            end
            count_in = count_ff + CNT_BITS'(1);
            total_in = total_ff + TOT_BITS'(val_ff);
         end
      end else begin
         if (!found) begin
            status_in = STATUS_MISS;
         end else begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (ge_ff[i]) begin
                  slot_in[i] = next_key[i];
               end
            end
            count_in = count_ff - CNT_BITS'(1);
            total_in = total_ff - TOT_BITS'(val_ff);
         end
      end
   end

   always_comb begin
      rsp_in.status      = status_in;
      rsp_in.entry_count = (32'(count_in) > 32'd31) ? OUT_COUNT_BITS'(31)
                                                    : OUT_COUNT_BITS'(count_in);
      rsp_in.value_total = (32'(total_in) > 32'd255) ? OUT_TOTAL_BITS'(255)
                                                     : OUT_TOTAL_BITS'(total_in);
      rsp_in.head_valid  = (count_in != '0);
      if (rsp_in.head_valid) begin
         rsp_in.head_value = IN_VALUE_BITS'(slot_in[0][KEY_BITS-1:SUIT_BITS]);
         rsp_in.head_suit  = slot_in[0][SUIT_BITS-1:0];
      end else begin
         rsp_in.head_value = '0;
         rsp_in.head_suit  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_data.mode;
         val_ff  <= VALUE_BITS'(req_data.card_value);
         key_ff  <= {VALUE_BITS'(req_data.card_value), req_data.card_suit};
      end
      if (cmd.compare) begin
         ge_ff   <= ge_in;
         eq_ff   <= eq_in;
         ins_ff  <= ins_in;
         full_ff <= full_in;
      end
      if (cmd.apply) begin
         slot_ff <= slot_in;
         rsp_ff  <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
